[sv/mke_pkg.sv]
`timescale 1ns / 1ps

package mke_pkg;

    localparam int POS_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int AXES       = 3;
    localparam int PROD_W     = 64;
    localparam int KEY_W      = 94;
    localparam int KEY_LO_W   = 64;
    localparam int KEY_HI_W   = 30;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 96;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Y  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Z  = 3'd5;

    // per-stage load strobes shared by the datapath modules
    typedef struct packed {
        logic ld_sub;
        logic ld_mul;
        logic ld_sat;
        logic ld_out;
    } mke_stage_en_t;

endpackage

[sv/morton_key_encode_3d_top.sv]
`timescale 1ns / 1ps

// 3D Morton key encoder.
// s_ channel: one position per transfer, s_tdata = pos_x, pos_y, pos_z
// (signed fixed point, FRAC_BITS fraction bits). m_ channel: one key per
// transfer, m_tdata = key_low, key_high; m_tuser = clamped.
// Each axis index is (pos - origin) * scale with the fraction dropped toward
// zero, saturated to 0 .. 2^COORD_BITS-1; clamped flags any saturation.
// Origins and scales are set through cfg_wr_en/cfg_addr/cfg_wdata while
// the pipeline is empty, a rule for the user that the block does not
// enforce; writes to unused indexes are dropped. Pipeline: subtract,
// multiply, saturate, interleave; four register stages. m_tvalid rises
// when a position reaches the output register. Throughput is one position
// per cycle while m_tready stays high: every stage, the 32x32 multiply
// included, is fully pipelined. Reset (aresetn low, synchronous) empties
// the pipeline, origins go to 0 and scales to unit (1 << FRAC_BITS). When
// m_tready is low the stages fill up behind the output register and
// s_tready drops once all are full; nothing is lost or repeated.
module morton_key_encode_3d_top #(
    parameter int COORD_BITS = 31,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mke_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [mke_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mke_pkg::S_DATA_W-1:0]         s_tdata,  // pos_x, pos_y, pos_z
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mke_pkg::M_DATA_W-1:0]         m_tdata,  // key_low, key_high, pad
    output logic                                 m_tuser   // clamped
);
    import mke_pkg::*;

    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [POS_W-1:0]        scale_x_reg, scale_y_reg, scale_z_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    mke_stage_en_t stage_en;

    logic [COORD_BITS-1:0] idx_x, idx_y, idx_z;
    logic                  clamp_x, clamp_y, clamp_z;
    logic [KEY_W-1:0]      key;
    logic                  clamped;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            scale_x_reg  <= POS_W'(1) << FRAC_BITS;
            scale_y_reg  <= POS_W'(1) << FRAC_BITS;
            scale_z_reg  <= POS_W'(1) << FRAC_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_ORIGIN_Z: origin_z_reg <= cfg_wdata;
                REG_SCALE_X:  scale_x_reg  <= cfg_wdata;
                REG_SCALE_Y:  scale_y_reg  <= cfg_wdata;
                REG_SCALE_Z:  scale_z_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage can load when it is empty or its content moves on
    assign rdy4 = ~v4_reg | m_tready;
    assign rdy3 = ~v3_reg | rdy4;
    assign rdy2 = ~v2_reg | rdy3;
    assign rdy1 = ~v1_reg | rdy2;

    assign stage_en.ld_sub = rdy1 & s_tvalid;
    assign stage_en.ld_mul = rdy2 & v1_reg;
    assign stage_en.ld_sat = rdy3 & v2_reg;
    assign stage_en.ld_out = rdy4 & v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign s_tready = rdy1;

    mke_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .aclk     (aclk),
        .stage_en (stage_en),
        .pos      (s_tdata[POS_W-1:0]),
        .origin   (origin_x_reg),
        .scale    (scale_x_reg),
        .idx      (idx_x),
        .clamp    (clamp_x)
    );

    mke_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .aclk     (aclk),
        .stage_en (stage_en),
        .pos      (s_tdata[2*POS_W-1:POS_W]),
        .origin   (origin_y_reg),
        .scale    (scale_y_reg),
        .idx      (idx_y),
        .clamp    (clamp_y)
    );

    mke_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_z (
        .aclk     (aclk),
        .stage_en (stage_en),
        .pos      (s_tdata[3*POS_W-1:2*POS_W]),
        .origin   (origin_z_reg),
        .scale    (scale_z_reg),
        .idx      (idx_z),
        .clamp    (clamp_z)
    );

    mke_interleave #(.COORD_BITS(COORD_BITS)) u_interleave (
        .aclk     (aclk),
        .stage_en (stage_en),
        .idx_x    (idx_x),
        .idx_y    (idx_y),
        .idx_z    (idx_z),
        .clamp_x  (clamp_x),
        .clamp_y  (clamp_y),
        .clamp_z  (clamp_z),
        .key      (key),
        .clamped  (clamped)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {(M_DATA_W - KEY_W)'(0), key};
    assign m_tuser  = clamped;

`ifndef SYNTHESIS
    a_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[AXES*COORD_BITS] == 1'b1)
        else $error("key sentinel bit missing");

    a_key_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[KEY_W-1:0] >> (AXES*COORD_BITS + 1)) == '0)
        else $error("key bits above sentinel not zero");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item not in first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && v4_reg && !m_tready) |=> v3_reg && v4_reg)
        else $error("item dropped from pipeline during stall");
`endif

endmodule

[sv/mke_axis.sv]
`timescale 1ns / 1ps

module mke_axis #(
    parameter int COORD_BITS = 31,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  mke_pkg::mke_stage_en_t        stage_en,
    input  logic signed [mke_pkg::POS_W-1:0] pos,
    input  logic signed [mke_pkg::POS_W-1:0] origin,
    input  logic [mke_pkg::POS_W-1:0]     scale,
    output logic [COORD_BITS-1:0]         idx,
    output logic                          clamp
);
    import mke_pkg::*;

    logic [POS_W:0]          diff;
    logic [POS_W:0]          diff_neg;
    logic [POS_W-1:0]        mag_next;
    logic [POS_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg2_reg;
    logic [PROD_W-1:0]       whole;
    logic                    over_top;
    logic [COORD_BITS-1:0]   idx_next;
    logic                    clamp_next;
    logic [COORD_BITS-1:0]   idx_reg;
    logic                    clamp_reg;

    // stage 1: exact 33-bit difference; its magnitude always fits 32 bits
    assign diff     = {pos[POS_W-1], pos} - {origin[POS_W-1], origin};
    assign diff_neg = (~diff) + 1'b1;
    assign mag_next = diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en.ld_sub) begin
            mag_reg <= mag_next;
            neg_reg <= diff[POS_W];
        end
    end

    // stage 2: 32x32 unsigned multiply
    always_ff @(posedge aclk) begin
        if (stage_en.ld_mul) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(scale);
            neg2_reg <= neg_reg;
        end
    end

    // stage 3: drop fraction bits, saturate to grid range
    assign whole    = prod_reg >> (2 * FRAC_BITS);
    assign over_top = (whole >> COORD_BITS) != '0;

    always_comb begin
        if (neg2_reg) begin
            idx_next   = '0;
            clamp_next = (whole != '0);
        end else if (over_top) begin
            idx_next   = '1;
            clamp_next = 1'b1;
        end else begin
            idx_next   = whole[COORD_BITS-1:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld_sat) begin
            idx_reg   <= idx_next;
            clamp_reg <= clamp_next;
        end
    end

    assign idx   = idx_reg;
    assign clamp = clamp_reg;

endmodule

[sv/mke_interleave.sv]
`timescale 1ns / 1ps

module mke_interleave #(
    parameter int COORD_BITS = 31
) (
    input  logic                       aclk,
    input  mke_pkg::mke_stage_en_t     stage_en,
    input  logic [COORD_BITS-1:0]      idx_x,
    input  logic [COORD_BITS-1:0]      idx_y,
    input  logic [COORD_BITS-1:0]      idx_z,
    input  logic                       clamp_x,
    input  logic                       clamp_y,
    input  logic                       clamp_z,
    output logic [mke_pkg::KEY_W-1:0]  key,
    output logic                       clamped
);
    import mke_pkg::*;

    logic [KEY_W-1:0] key_next;
    logic [KEY_W-1:0] key_reg;
    logic             clamped_reg;

    always_comb begin
        key_next = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            key_next[AXES*i]     = idx_x[i];
            key_next[AXES*i + 1] = idx_y[i];
            key_next[AXES*i + 2] = idx_z[i];
        end
        key_next[AXES*COORD_BITS] = 1'b1;   // sentinel
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld_out) begin
            key_reg     <= key_next;
            clamped_reg <= clamp_x | clamp_y | clamp_z;
        end
    end

    assign key     = key_reg;
    assign clamped = clamped_reg;

endmodule

[dv/morton_key_encode_3d_top_tb.sv]
`timescale 1ns / 1ps

module morton_key_encode_3d_top_tb;
    import mke_pkg::*;

    localparam int COORD_BITS  = 31;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    // indexes with no register behind them; writes must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_7 = 3'd7;

    localparam logic [CFG_W-1:0] UNIT_SCALE = 32'h0001_0000;
    localparam logic [CFG_W-1:0] MAX_SCALE  = 32'hffff_ffff;
    localparam logic [POS_W-1:0] POS_MIN    = 32'h8000_0000;
    localparam logic [POS_W-1:0] POS_MAX    = 32'h7fff_ffff;
    localparam logic [63:0]      TOP_INDEX  = (64'd1 << COORD_BITS) - 64'd1;

    typedef struct {
        logic [KEY_LO_W-1:0] key_lo;
        logic [KEY_HI_W-1:0] key_hi;
        logic                clamped;
    } morton_key_t;

    class key_checker;
        logic [CFG_W-1:0] origin [AXES];
        logic [CFG_W-1:0] scale [AXES];
        morton_key_t      want_keys [$];
        int               errors;

        function new();
            for (int a = 0; a < AXES; a++) begin
                origin[a] = '0;
                scale[a]  = UNIT_SCALE;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_ORIGIN_X: origin[0] = val;
                REG_ORIGIN_Y: origin[1] = val;
                REG_ORIGIN_Z: origin[2] = val;
                REG_SCALE_X:  scale[0]  = val;
                REG_SCALE_Y:  scale[1]  = val;
                REG_SCALE_Z:  scale[2]  = val;
                default: ;
            endcase
        endfunction

        // (pos - origin) * scale, fraction dropped toward zero, saturated
        function logic [COORD_BITS-1:0] grid_index(logic [POS_W-1:0] pos, int axis,
                                                    inout bit clamp);
            longint      diff;
            logic [63:0] mag;
            logic [63:0] whole;
            diff  = longint'($signed(pos)) - longint'($signed(origin[axis]));
            mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
            whole = (mag * {32'd0, scale[axis]}) >> (2 * FRAC_BITS);
            if (diff < 0) begin
                // (-1, 0) truncates to zero without clamping
                if (whole != 64'd0)
                    clamp = 1'b1;
                return '0;
            end
            if (whole > TOP_INDEX) begin
                clamp = 1'b1;
                return TOP_INDEX[COORD_BITS-1:0];
            end
            return whole[COORD_BITS-1:0];
        endfunction

        function void note_position(logic [S_DATA_W-1:0] pos);
            logic [COORD_BITS-1:0] idx [AXES];
            logic [KEY_W-1:0]      key;
            bit                    clamp;
            morton_key_t           k;
            clamp = 1'b0;
            key   = '0;
            for (int a = 0; a < AXES; a++)
                idx[a] = grid_index(pos[a*POS_W +: POS_W], a, clamp);
            for (int i = 0; i < COORD_BITS; i++)
                for (int a = 0; a < AXES; a++)
                    key[AXES*i + a] = idx[a][i];
            key[AXES*COORD_BITS] = 1'b1;
            k.key_lo  = key[KEY_LO_W-1:0];
            k.key_hi  = key[KEY_W-1:KEY_LO_W];
            k.clamped = clamp;
            want_keys.push_back(k);
        endfunction

        function void complain(string field, logic [63:0] exp_v, logic [63:0] got_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("key mismatch on %s: expected %h, got %h", field, exp_v, got_v);
        endfunction

        function void check_key(logic [M_DATA_W-1:0] data, logic user);
            morton_key_t k;
            if (want_keys.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("key transfer with nothing expected: %h", data);
                return;
            end
            k = want_keys.pop_front();
            if (data[KEY_LO_W-1:0] !== k.key_lo)
                complain("key_low", k.key_lo, data[KEY_LO_W-1:0]);
            if (data[KEY_LO_W +: KEY_HI_W] !== k.key_hi)
                complain("key_high", 64'(k.key_hi), 64'(data[KEY_LO_W +: KEY_HI_W]));
            if (user !== k.clamped)
                complain("clamped", 64'(k.clamped), 64'(user));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;  // pos_x, pos_y, pos_z
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // key_low, key_high, pad
    logic                  m_tuser;         // clamped

    key_checker  keys     = new();
    bit          tx_idle  = 1'b1;
    bit          rx_idle  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned cycles   = 0;

    morton_key_encode_3d_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("morton_key_encode_3d_top_tb: done, errors");
            $finish;
        end
    end

    task automatic send_position(input logic [POS_W-1:0] x, y, z);
        while (tx_idle && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        keys.note_position({z, y, x});
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (keys.want_keys.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        keys.write_reg(idx, val);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] ox, oy, oz, sx, sy, sz);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_SCALE_Z, sz);
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_7 : REG_UNMAPPED_6, $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_origin();
        case ($urandom_range(0, 5))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return UNIT_SCALE;
            1:       return '0;
            2:       return MAX_SCALE;
            3:       return $urandom();
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // mostly near the origin so indices spread; some below it to clamp low
    function automatic logic [POS_W-1:0] rand_pos(input logic [CFG_W-1:0] org);
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return org + 32'($urandom_range(0, 2)) - 32'd1;
            2:       return org - ($urandom() >> $urandom_range(8, 31));
            3:       return org + ($urandom() >> $urandom_range(8, 31));
            default: return org + ($urandom() >> $urandom_range(0, 31));
        endcase
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !rx_idle || ($urandom_range(0, 99) >= 34);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready)
                keys.check_key(m_tdata, m_tuser);
        end
    end

    initial begin
        logic [CFG_W-1:0] org [AXES];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: unit scale, zero origin
        send_position('0, '0, '0);
        send_position(POS_MAX, POS_MAX, POS_MAX);
        send_position(POS_MIN, POS_MIN, POS_MIN);
        send_position(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_position(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
        send_position(32'hffff_0000, '0, '0);
        send_position(32'h0000_ffff, 32'h0001_ffff, POS_MAX);

        // lowest origin, largest scale: index lands exactly on the top, then just over
        load_config(POS_MIN, POS_MIN, POS_MIN, MAX_SCALE, MAX_SCALE, MAX_SCALE);
        send_position('0, '0, '0);
        send_position(32'd1, 32'd1, 32'd1);
        send_position(POS_MAX, POS_MAX, POS_MAX);
        send_position(POS_MIN, POS_MIN, POS_MIN);
        send_position('0, 32'd1, POS_MIN);

        // zero scale: always index 0, never clamped
        load_config(POS_MAX, POS_MAX, POS_MAX, '0, '0, '0);
        send_position(POS_MIN, POS_MIN, POS_MIN);
        send_position(POS_MAX, POS_MAX, POS_MAX);
        send_position('0, 32'hffff_ffff, 32'h1234_5678);

        for (int p = 0; p < N_PHASES; p++) begin
            for (int a = 0; a < AXES; a++)
                org[a] = rand_origin();
            load_config(org[0], org[1], org[2], rand_scale(), rand_scale(), rand_scale());
            tx_idle = (p != 2);
            rx_idle = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == 10)
                    hold_req = 1'b1;
                send_position(rand_pos(org[0]), rand_pos(org[1]), rand_pos(org[2]));
            end
        end

        drain();
        repeat (LATENCY * 4) @(posedge aclk);
        if (keys.errors == 0 && keys.want_keys.size() == 0)
            $display("morton_key_encode_3d_top_tb: done, clean");
        else
            $display("morton_key_encode_3d_top_tb: done, errors");
        $finish;
    end

endmodule
